/* rtl/smpd_pkg.sv */
package smpd_pkg;

	localparam int POS_BITS = 12;
	localparam int CFG_W    = 12;
	localparam int DELTA_W  = 8;
	localparam int BYTE_W   = 8;
	localparam int SUM_W    = ((POS_BITS > CFG_W) ? POS_BITS : CFG_W) + 2;

	localparam logic [POS_BITS-1:0] POS_MASK = '1;

	localparam logic [CFG_W-1:0] MAX_X_RESET = CFG_W'(79);
	localparam logic [CFG_W-1:0] MAX_Y_RESET = CFG_W'(24);

	typedef enum logic {
		REG_MAX_X = 1'b0,
		REG_MAX_Y = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                      done;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic                      left;
		logic                      right;
	} pkt_t;

	typedef struct packed {
		logic [POS_BITS-1:0]       pos_x;
		logic [POS_BITS-1:0]       pos_y;
		logic signed [DELTA_W-1:0] delta_x;
		logic signed [DELTA_W-1:0] delta_y;
		logic                      left_button;
		logic                      right_button;
	} res_t;

	function automatic logic [POS_BITS-1:0] move_clamp(
		input logic [POS_BITS-1:0]       cur,
		input logic signed [DELTA_W-1:0] d,
		input logic [CFG_W-1:0]          limit
	);
		logic signed [SUM_W-1:0] s;
		logic signed [SUM_W-1:0] lim;
		logic signed [SUM_W-1:0] pmax;
		logic [POS_BITS-1:0]     r;
		s    = signed'(SUM_W'(cur)) + SUM_W'(d);
		lim  = signed'(SUM_W'(limit));
		pmax = signed'(SUM_W'(POS_MASK));
		if (lim > pmax)
			lim = pmax;
		if (s < 0)
			r = '0;
		else if (s > lim)
			r = POS_BITS'(lim);
		else
			r = POS_BITS'(s);
		return r;
	endfunction

endpackage

/* rtl/smpd_if.sv */
interface smpd_in_if import smpd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface smpd_out_if import smpd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [POS_BITS-1:0]       pos_x;
	logic [POS_BITS-1:0]       pos_y;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;
	logic                      left_button;
	logic                      right_button;

	modport source (output valid, output pos_x, output pos_y, output delta_x,
		output delta_y, output left_button, output right_button, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input delta_x,
		input delta_y, input left_button, input right_button, output ready);
endinterface

/* rtl/smpd_assembler.sv */
module smpd_assembler import smpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] byte_s1,
	output pkt_t              pkt
);

	typedef enum logic [1:0] {
		PH_SYNC   = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	phase_t                    phase_q;
	logic   [1:0]              buttons_q;
	logic   [DELTA_W-1:0]      dx_q;
	logic   [DELTA_W-1:0]      dy_q;

	logic                      is_sync;

	assign is_sync = byte_s1[6];

	always_comb begin
		pkt.done  = !is_sync && (phase_q == PH_THIRD);
		pkt.dx    = signed'(dx_q);
		pkt.dy    = signed'({dy_q[7:6], byte_s1[5:0]});
		pkt.left  = buttons_q[1];
		pkt.right = buttons_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC;
			buttons_q <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
		end else if (step) begin
			if (is_sync) begin
				buttons_q <= byte_s1[5:4];
				dx_q      <= {byte_s1[1:0], 6'd0};
				dy_q      <= {byte_s1[3:2], 6'd0};
				phase_q   <= PH_SECOND;
			end else begin
				case (phase_q)
					PH_SECOND: begin
						dx_q    <= {dx_q[7:6], byte_s1[5:0]};
						phase_q <= PH_THIRD;
					end
					PH_THIRD: begin
						dy_q    <= {dy_q[7:6], byte_s1[5:0]};
						phase_q <= PH_SYNC;
					end
					default: phase_q <= PH_SYNC;
				endcase
			end
		end
	end

endmodule

/* rtl/smpd_cursor.sv */
module smpd_cursor import smpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             update,
	input  pkt_t             pkt,
	input  logic [CFG_W-1:0] max_x,
	input  logic [CFG_W-1:0] max_y,
	output res_t             res
);

	logic [POS_BITS-1:0] cur_x_q;
	logic [POS_BITS-1:0] cur_y_q;

	always_comb begin
		res.pos_x        = move_clamp(cur_x_q, pkt.dx, max_x);
		res.pos_y        = move_clamp(cur_y_q, pkt.dy, max_y);
		res.delta_x      = pkt.dx;
		res.delta_y      = pkt.dy;
		res.left_button  = pkt.left;
		res.right_button = pkt.right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else if (update) begin
			cur_x_q <= res.pos_x;
			cur_y_q <= res.pos_y;
		end
	end

endmodule

/* rtl/serial_mouse_packet_decoder.sv */
// Decoder for the 3-byte two-button serial mouse protocol. Each received byte is one
// transfer on in_ch; bit 7 is ignored and a byte with bit 6 set starts a packet. The third
// byte of a packet yields one transfer on out_ch with the clamped cursor position
// (0..max_x, 0..max_y), the signed deltas and the buttons; all other bytes yield nothing.
// Input reaches out_ch via the input register, then the result register; a byte can be
// taken every cycle, and only a packet result held in the input register behind an unread
// result stalls in_ch. max_x/max_y (reset values 79/24) are written through cfg_we, cfg_index
// (0 = max_x, 1 = max_y) and cfg_wdata by users only while the block is idle; not enforced.
module serial_mouse_packet_decoder import smpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	smpd_in_if.sink          in_ch,
	smpd_out_if.source       out_ch
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [CFG_W-1:0]  max_x_q;
	logic [CFG_W-1:0]  max_y_q;
	logic              res_valid_q;
	res_t              res_q;

	pkt_t              pkt;
	res_t              res_next;
	logic              step;
	logic              done;

	assign done        = valid_s1 && pkt.done;
	assign step        = valid_s1 && (!pkt.done || !res_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RESET;
			max_y_q <= MAX_Y_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_X: max_x_q <= cfg_wdata;
				REG_MAX_Y: max_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid)
			byte_s1 <= in_ch.rx_byte;
	end

	smpd_assembler u_asm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.pkt     (pkt)
	);

	smpd_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.update (step && done),
		.pkt    (pkt),
		.max_x  (max_x_q),
		.max_y  (max_y_q),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (step && done)
			res_valid_q <= 1'b1;
		else if (out_ch.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && done)
			res_q <= res_next;
	end

	assign out_ch.valid        = res_valid_q;
	assign out_ch.pos_x        = res_q.pos_x;
	assign out_ch.pos_y        = res_q.pos_y;
	assign out_ch.delta_x      = res_q.delta_x;
	assign out_ch.delta_y      = res_q.delta_y;
	assign out_ch.left_button  = res_q.left_button;
	assign out_ch.right_button = res_q.right_button;

endmodule

/* rtl/smpd_checker.sv */
module smpd_checker import smpd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [POS_BITS-1:0]       pos_x,
	input logic [POS_BITS-1:0]       pos_y,
	input logic signed [DELTA_W-1:0] delta_x,
	input logic signed [DELTA_W-1:0] delta_y
);

	// a result only appears after a byte transfer has passed the input and result registers
	a_rose_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a preceding input transfer");

	// with the result register empty, the input side never stalls
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while result register empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y)
			&& $stable(delta_x) && $stable(delta_y))
		else $error("result changed while stalled");

endmodule

bind serial_mouse_packet_decoder smpd_checker u_smpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.pos_x     (out_ch.pos_x),
	.pos_y     (out_ch.pos_y),
	.delta_x   (out_ch.delta_x),
	.delta_y   (out_ch.delta_y)
);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import smpd_pkg::*;

	typedef enum logic [1:0] {
		WAIT_SYNC,
		WANT_X_LOW,
		WANT_Y_LOW
	} pkt_phase_t;

	localparam int HOLD_EVERY  = 16;
	localparam int HOLD_CYCLES = 40;
	localparam int POS_TOP     = (1 << POS_BITS) - 1;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	cfg_reg_t          cfg_idx;
	logic [CFG_W-1:0]  cfg_wdata;

	smpd_in_if  in_ch ();
	smpd_out_if out_ch ();

	serial_mouse_packet_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// decoder shadow state
	pkt_phase_t          pkt_phase;
	logic                btn_left;
	logic                btn_right;
	logic [7:0]          acc_dx;
	logic [7:0]          acc_dy;
	logic [POS_BITS-1:0] cursor_x;
	logic [POS_BITS-1:0] cursor_y;
	logic [CFG_W-1:0]    limit_x;
	logic [CFG_W-1:0]    limit_y;

	logic [BYTE_W-1:0] byte_q[$];
	res_t              motion_q[$];

	int   in_wait;
	int   rdy_wait;
	int   rdy_pause;
	int   in_gap_max;
	int   out_gap_max;
	int   err_count;
	int   res_count;
	logic in_xfer;
	logic out_xfer;

	always #6 clk = ~clk;

	function automatic logic [POS_BITS-1:0] move_axis(logic [POS_BITS-1:0] cur,
		logic signed [7:0] d, logic [CFG_W-1:0] lim);
		int sum;
		int top;
		top = int'(lim);
		if (top > POS_TOP)
			top = POS_TOP;
		sum = int'(cur) + int'(d);
		if (sum < 0)
			sum = 0;
		if (sum > top)
			sum = top;
		return POS_BITS'(sum);
	endfunction

	task automatic decode_byte(logic [7:0] b);
		res_t r;
		if (b[6]) begin
			btn_left = b[5];
			btn_right = b[4];
			acc_dx = {b[1:0], 6'b0};
			acc_dy = {b[3:2], 6'b0};
			pkt_phase = WANT_X_LOW;
		end else begin
			case (pkt_phase)
				WANT_X_LOW: begin
					acc_dx[5:0] = b[5:0];
					pkt_phase = WANT_Y_LOW;
				end
				WANT_Y_LOW: begin
					acc_dy[5:0] = b[5:0];
					cursor_x = move_axis(cursor_x, acc_dx, limit_x);
					cursor_y = move_axis(cursor_y, acc_dy, limit_y);
					r.pos_x = cursor_x;
					r.pos_y = cursor_y;
					r.delta_x = acc_dx;
					r.delta_y = acc_dy;
					r.left_button = btn_left;
					r.right_button = btn_right;
					motion_q.push_back(r);
					pkt_phase = WAIT_SYNC;
				end
				default: pkt_phase = WAIT_SYNC;
			endcase
		end
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	// transfer accounting and result check
	always @(posedge clk) begin
		in_xfer <= arst_n && in_ch.valid && in_ch.ready;
		out_xfer <= arst_n && out_ch.valid && out_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready)
			decode_byte(in_ch.rx_byte);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			res_count++;
			if (motion_q.size() == 0) begin
				$error("unexpected result: pos_x %0d pos_y %0d", out_ch.pos_x, out_ch.pos_y);
				err_count++;
			end else begin
				res_t e;
				e = motion_q.pop_front();
				check_field("pos_x", e.pos_x, out_ch.pos_x);
				check_field("pos_y", e.pos_y, out_ch.pos_y);
				check_field("delta_x", e.delta_x, out_ch.delta_x);
				check_field("delta_y", e.delta_y, out_ch.delta_y);
				check_field("left_button", e.left_button, out_ch.left_button);
				check_field("right_button", e.right_button, out_ch.right_button);
			end
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.rx_byte <= '0;
			in_wait <= 0;
		end else if (!in_ch.valid || in_xfer) begin
			if (in_wait != 0) begin
				in_ch.valid <= 1'b0;
				in_wait <= in_wait - 1;
			end else if (byte_q.size() != 0) begin
				in_ch.valid <= 1'b1;
				in_ch.rx_byte <= byte_q.pop_front();
				in_wait <= $urandom_range(0, in_gap_max);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result sink; long hold-off under back-to-back input
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rdy_wait <= 0;
		end else if (rdy_wait != 0) begin
			out_ch.ready <= 1'b0;
			rdy_wait <= rdy_wait - 1;
		end else if (out_xfer) begin
			if (in_gap_max == 0 && res_count % HOLD_EVERY == 0)
				rdy_pause = HOLD_CYCLES;
			else
				rdy_pause = $urandom_range(0, out_gap_max);
			out_ch.ready <= (rdy_pause == 0);
			rdy_wait <= (rdy_pause == 0) ? 0 : rdy_pause - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic queue_packet(logic [7:0] dx, logic [7:0] dy, logic l, logic r);
		byte_q.push_back({1'($urandom), 1'b1, l, r, dy[7:6], dx[7:6]});
		byte_q.push_back({1'($urandom), 1'b0, dx[5:0]});
		byte_q.push_back({1'($urandom), 1'b0, dy[5:0]});
	endtask

	task automatic queue_traffic(int n_bytes);
		int made;
		int k;
		made = 0;
		while (made < n_bytes) begin
			k = $urandom_range(0, 9);
			if (k < 7) begin
				queue_packet(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
				made += 3;
			end else if (k == 7) begin
				byte_q.push_back(8'($urandom));
				made++;
			end else if (k == 8) begin
				// packet cut short by a new sync byte
				byte_q.push_back({1'($urandom), 1'b1, 6'($urandom)});
				if ($urandom_range(0, 1))
					byte_q.push_back({1'($urandom), 1'b0, 6'($urandom)});
				made += 2;
			end else begin
				queue_packet(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
				byte_q.push_back({1'($urandom), 1'b0, 6'($urandom)});
				byte_q.push_back({1'($urandom), 1'b0, 6'($urandom)});
				made += 5;
			end
		end
	endtask

	task automatic wait_idle(int settle);
		int guard;
		guard = 0;
		while ((byte_q.size() != 0 || in_ch.valid || motion_q.size() != 0) && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (settle) @(negedge clk);
	endtask

	task automatic set_limit(cfg_reg_t r, logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_wdata <= v;
		if (r == REG_MAX_X)
			limit_x = v;
		else
			limit_y = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_W-1:0] mx, logic [CFG_W-1:0] my, int in_max,
		int out_max, int n_bytes);
		set_limit(REG_MAX_X, mx);
		set_limit(REG_MAX_Y, my);
		in_gap_max = in_max;
		out_gap_max = out_max;
		queue_traffic(n_bytes);
		wait_idle(8);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MAX_X;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.rx_byte = '0;
		out_ch.ready = 1'b0;
		in_wait = 0;
		rdy_wait = 0;
		in_xfer = 1'b0;
		out_xfer = 1'b0;
		err_count = 0;
		res_count = 0;
		in_gap_max = 1;
		out_gap_max = 1;
		pkt_phase = WAIT_SYNC;
		btn_left = 1'b0;
		btn_right = 1'b0;
		acc_dx = '0;
		acc_dy = '0;
		cursor_x = '0;
		cursor_y = '0;
		limit_x = MAX_X_RESET;
		limit_y = MAX_Y_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// noise before any sync byte
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hBF);
		byte_q.push_back(8'h25);
		// clamp at the reset limits, then at zero
		queue_packet(8'd127, 8'd127, 1'b1, 1'b0);
		queue_packet(8'h80, 8'h80, 1'b0, 1'b1);
		queue_packet(8'hFF, 8'h01, 1'b1, 1'b1);
		// bytes past the third one
		byte_q.push_back(8'h3F);
		byte_q.push_back(8'h80);
		// sync byte in mid-packet
		byte_q.push_back(8'h7F);
		byte_q.push_back(8'h3F);
		queue_packet(8'h05, 8'hFD, 1'b0, 1'b0);
		byte_q.push_back(8'hCF);
		queue_packet(8'h00, 8'h00, 1'b0, 1'b0);
		wait_idle(8);

		run_phase(12'hFFF, 12'hFFF, 0, 0, 90);
		run_phase(12'h000, 12'h000, 4, 4, 60);
		run_phase(12'($urandom), 12'($urandom), 0, 4, 90);
		run_phase(12'h001, 12'hFFE, 4, 0, 60);
		run_phase(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)), 2, 2, 100);

		if (motion_q.size() != 0) begin
			$error("%0d results never arrived", motion_q.size());
			err_count++;
		end
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* serial_mouse_packet_decoder.f */
rtl/smpd_pkg.sv
rtl/smpd_if.sv
rtl/smpd_assembler.sv
rtl/smpd_cursor.sv
rtl/serial_mouse_packet_decoder.sv
rtl/smpd_checker.sv
tb/tb.sv
